[hdl/srsm_pkg.sv]
// Shared types and codes for the stepped range size and membership block.
// No dependencies; imported by every module in hdl/.
`default_nettype none
package srsm_pkg;

    localparam int FIELD_WIDTH = 64;
    localparam int COUNT_WIDTH = 63;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_STEP = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_STOP  = 2'd1;
    localparam logic [1:0] CFG_STEP  = 2'd2;

    // per-item control that rides along the divider stages
    typedef struct packed {
        logic [1:0] status;
        logic       nonempty;
        logic       in_range;
    } srsm_ctl_t;

endpackage
`default_nettype wire

[hdl/srsm_front.sv]
// Front end: span and offset subtraction with overflow checks, then
// magnitudes and bounds compare. Two register stages. Uses srsm_pkg.
`default_nettype none
module srsm_front
    import srsm_pkg::*;
#(
    parameter int W = 64
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         in_valid,
    input  wire logic [W-1:0] query,
    input  wire logic [W-1:0] start,
    input  wire logic [W-1:0] stop,
    input  wire logic [W-1:0] step,
    output logic              valid_b,
    output srsm_ctl_t         ctl_b,
    output logic [W-1:0]      ms_b,
    output logic [W-1:0]      mt_b,
    output logic [W-1:0]      md_b
);

    // stage A
    logic         valid_a_reg;
    logic [1:0]   status_a_reg, status_a_next;
    logic [W-1:0] span_a_reg, span_a_next;
    logic [W-1:0] d_a_reg, d_a_next;
    logic [W-1:0] step_a_reg;
    logic         qfit_a_reg, qfit_a_next;

    always_comb
    begin
        span_a_next = stop - start;
        d_a_next    = query - start;
        qfit_a_next = !((query[W-1] != start[W-1]) && (d_a_next[W-1] != query[W-1]));
        if (step == '0)
            status_a_next = ST_ZERO_STEP;
        else if ((stop[W-1] != start[W-1]) && (span_a_next[W-1] != stop[W-1]))
            status_a_next = ST_OVERFLOW;
        else
            status_a_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else if (en)
            valid_a_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_a_reg <= status_a_next;
            span_a_reg   <= span_a_next;
            d_a_reg      <= d_a_next;
            step_a_reg   <= step;
            qfit_a_reg   <= qfit_a_next;
        end
    end

    // stage B
    logic         valid_b_reg;
    srsm_ctl_t    ctl_b_reg, ctl_b_next;
    logic [W-1:0] ms_b_reg, mt_b_reg, md_b_reg;
    logic         span_neg, step_neg, d_neg, in_span;

    always_comb
    begin
        span_neg = span_a_reg[W-1];
        step_neg = step_a_reg[W-1];
        d_neg    = d_a_reg[W-1];
        if (!step_neg)
            in_span = !d_neg && ($signed(d_a_reg) < $signed(span_a_reg));
        else
            in_span = (d_neg || (d_a_reg == '0)) && ($signed(span_a_reg) < $signed(d_a_reg));
        ctl_b_next.status   = status_a_reg;
        ctl_b_next.nonempty = (status_a_reg == ST_OK) && (span_neg == step_neg);
        ctl_b_next.in_range = ctl_b_next.nonempty && qfit_a_reg && in_span;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_b_reg <= 1'b0;
        else if (en)
            valid_b_reg <= valid_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_b_reg <= ctl_b_next;
            ms_b_reg  <= span_a_reg[W-1] ? (W'(0) - span_a_reg) : span_a_reg;
            mt_b_reg  <= step_a_reg[W-1] ? (W'(0) - step_a_reg) : step_a_reg;
            md_b_reg  <= d_a_reg[W-1]    ? (W'(0) - d_a_reg)    : d_a_reg;
        end
    end

    assign valid_b = valid_b_reg;
    assign ctl_b   = ctl_b_reg;
    assign ms_b    = ms_b_reg;
    assign mt_b    = mt_b_reg;
    assign md_b    = md_b_reg;

endmodule
`default_nettype wire

[hdl/srsm_div_stage.sv]
// One restoring-division step for two lanes sharing a divisor (count lane
// and membership lane); one quotient bit each per stage. Uses srsm_pkg.
`default_nettype none
module srsm_div_stage
    import srsm_pkg::*;
#(
    parameter int W = 64
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         valid_in,
    input  wire srsm_ctl_t    ctl_in,
    input  wire logic [W-1:0] divisor_in,
    input  wire logic [W-1:0] rem_c_in,
    input  wire logic [W-1:0] quo_c_in,
    input  wire logic [W-1:0] rem_m_in,
    input  wire logic [W-1:0] quo_m_in,
    output logic              valid_out,
    output srsm_ctl_t         ctl_out,
    output logic [W-1:0]      divisor_out,
    output logic [W-1:0]      rem_c_out,
    output logic [W-1:0]      quo_c_out,
    output logic [W-1:0]      rem_m_out,
    output logic [W-1:0]      quo_m_out
);

    logic         valid_reg;
    srsm_ctl_t    ctl_reg;
    logic [W-1:0] div_reg, rem_c_reg, quo_c_reg, rem_m_reg, quo_m_reg;
    logic [W-1:0] sh_c, sh_m;
    logic [W:0]   tr_c, tr_m;

    always_comb
    begin
        // remainder stays below the divisor, so its top bit is always clear
        sh_c = {rem_c_in[W-2:0], quo_c_in[W-1]};
        sh_m = {rem_m_in[W-2:0], quo_m_in[W-1]};
        tr_c = {1'b0, sh_c} - {1'b0, divisor_in};
        tr_m = {1'b0, sh_m} - {1'b0, divisor_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg   <= ctl_in;
            div_reg   <= divisor_in;
            rem_c_reg <= tr_c[W] ? sh_c : tr_c[W-1:0];
            quo_c_reg <= {quo_c_in[W-2:0], !tr_c[W]};
            rem_m_reg <= tr_m[W] ? sh_m : tr_m[W-1:0];
            quo_m_reg <= {quo_m_in[W-2:0], !tr_m[W]};
        end
    end

    assign valid_out   = valid_reg;
    assign ctl_out     = ctl_reg;
    assign divisor_out = div_reg;
    assign rem_c_out   = rem_c_reg;
    assign quo_c_out   = quo_c_reg;
    assign rem_m_out   = rem_m_reg;
    assign quo_m_out   = quo_m_reg;

endmodule
`default_nettype wire

[hdl/srsm_back.sv]
// Back end: ceiling correction, saturation, membership decision and the
// output register. Uses srsm_pkg.
`default_nettype none
module srsm_back
    import srsm_pkg::*;
#(
    parameter int W = 64
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   valid_in,
    input  wire srsm_ctl_t              ctl_in,
    input  wire logic [W-1:0]           quo_c,
    input  wire logic [W-1:0]           rem_c,
    input  wire logic [W-1:0]           rem_m,
    output logic                        valid_out,
    output logic [COUNT_WIDTH-1:0]      count_out,
    output logic                        member_out,
    output logic [1:0]                  status_out
);

    localparam logic [W:0]   CMAX_WIDE = {2'b00, {(W-1){1'b1}}};
    localparam logic [W-2:0] CMAX      = {(W-1){1'b1}};

    logic                   valid_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   member_reg;
    logic [1:0]             status_reg;
    logic [W:0]             ceil_c;
    logic [W-2:0]           count_sat;

    always_comb
    begin
        ceil_c    = {1'b0, quo_c} + {{W{1'b0}}, (rem_c != '0)};
        count_sat = (ceil_c > CMAX_WIDE) ? CMAX : ceil_c[W-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg  <= ctl_in.nonempty ? COUNT_WIDTH'(count_sat) : '0;
            member_reg <= ctl_in.in_range && (rem_m == '0);
            status_reg <= ctl_in.status;
        end
    end

    assign valid_out  = valid_reg;
    assign count_out  = count_reg;
    assign member_out = member_reg;
    assign status_out = status_reg;

endmodule
`default_nettype wire

[hdl/stepped_range_size_and_membership.sv]
// Stepped range size and membership: for each query beat, returns the element
// count of the configured range (start, stop, step), whether the query is a
// member, and a status (0 ok, 1 zero step, 2 stop minus start overflows).
// Throughput is one beat per clock unless m_tready stalls; the pipeline is two
// front stages, one divider stage per quotient bit (DATA_WIDTH of them,
// dividing count span and query offset by |step| in parallel), and the output
// register. The whole pipeline advances together whenever the output register
// is empty or being taken, so a stall on m_tready holds every beat in place.
// Values use the low DATA_WIDTH bits of each field, sign-extended; the count
// saturates at 2^(DATA_WIDTH-1)-1. Configuration must be written while idle.
// Depends on srsm_pkg, srsm_front, srsm_div_stage, srsm_back.
`default_nettype none
module stepped_range_size_and_membership
    import srsm_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // query stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] query_value
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [62:0] element_count, [63] is_member,
                                        // [65:64] status, [71:66] zero
);

    localparam int W = DATA_WIDTH;

    logic [FIELD_WIDTH-1:0] start_reg, stop_reg, step_reg;

    // config is always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            stop_reg  <= '0;
            step_reg  <= FIELD_WIDTH'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START: start_reg <= cfg_data;
                CFG_STOP:  stop_reg  <= cfg_data;
                CFG_STEP:  step_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    // global advance: output slot free or being drained
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // front end
    logic         valid_f;
    srsm_ctl_t    ctl_f;
    logic [W-1:0] ms_f, mt_f, md_f;

    srsm_front #(.W(W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .query    (s_tdata[W-1:0]),
        .start    (start_reg[W-1:0]),
        .stop     (stop_reg[W-1:0]),
        .step     (step_reg[W-1:0]),
        .valid_b  (valid_f),
        .ctl_b    (ctl_f),
        .ms_b     (ms_f),
        .mt_b     (mt_f),
        .md_b     (md_f)
    );

    // divider chain; index 0 is the chain input
    logic         dv_valid [W+1];
    srsm_ctl_t    dv_ctl   [W+1];
    logic [W-1:0] dv_div   [W+1];
    logic [W-1:0] dv_rem_c [W+1];
    logic [W-1:0] dv_quo_c [W+1];
    logic [W-1:0] dv_rem_m [W+1];
    logic [W-1:0] dv_quo_m [W+1];

    assign dv_valid[0] = valid_f;
    assign dv_ctl[0]   = ctl_f;
    assign dv_div[0]   = mt_f;
    assign dv_rem_c[0] = '0;
    assign dv_quo_c[0] = ms_f;
    assign dv_rem_m[0] = '0;
    assign dv_quo_m[0] = md_f;

    genvar gi;
    generate
        for (gi = 0; gi < W; gi++)
        begin : g_div
            srsm_div_stage #(.W(W)) u_stage (
                .clk         (clk),
                .rst_n       (rst_n),
                .en          (en),
                .valid_in    (dv_valid[gi]),
                .ctl_in      (dv_ctl[gi]),
                .divisor_in  (dv_div[gi]),
                .rem_c_in    (dv_rem_c[gi]),
                .quo_c_in    (dv_quo_c[gi]),
                .rem_m_in    (dv_rem_m[gi]),
                .quo_m_in    (dv_quo_m[gi]),
                .valid_out   (dv_valid[gi+1]),
                .ctl_out     (dv_ctl[gi+1]),
                .divisor_out (dv_div[gi+1]),
                .rem_c_out   (dv_rem_c[gi+1]),
                .quo_c_out   (dv_quo_c[gi+1]),
                .rem_m_out   (dv_rem_m[gi+1]),
                .quo_m_out   (dv_quo_m[gi+1])
            );
        end
    endgenerate

    // back end and output register
    logic [COUNT_WIDTH-1:0] count_o;
    logic                   member_o;
    logic [1:0]             status_o;

    srsm_back #(.W(W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid_in   (dv_valid[W]),
        .ctl_in     (dv_ctl[W]),
        .quo_c      (dv_quo_c[W]),
        .rem_c      (dv_rem_c[W]),
        .rem_m      (dv_rem_m[W]),
        .valid_out  (m_tvalid),
        .count_out  (count_o),
        .member_out (member_o),
        .status_out (status_o)
    );

    assign m_tdata = {6'b000000, status_o, member_o, count_o};

`ifndef ASSERT_OFF
    // a fault status never carries a count or membership
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status_o != ST_OK) |-> (count_o == '0) && !member_o)
        else $error("fault status with nonzero result");

    // status code is one of the three defined values
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status_o == ST_OK) || (status_o == ST_ZERO_STEP)
                     || (status_o == ST_OVERFLOW))
        else $error("undefined status code");

    // a member implies a nonempty range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && member_o |-> (count_o != '0))
        else $error("member of an empty range");
`endif

endmodule
`default_nettype wire

[dv/tb_stepped_range_size_and_membership.sv]
// Testbench for stepped_range_size_and_membership: directed and random query beats
// against a behavioral range predictor, with random idling on both streams.
// Depends on srsm_pkg and the block RTL only.
`timescale 1ns / 100ps
module tb_stepped_range_size_and_membership;
    import srsm_pkg::*;

    localparam longint SMIN = 64'sh8000000000000000;
    localparam longint SMAX = 64'sh7fffffffffffffff;
    localparam int LATENCY = 64 + 3;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [62:0] count;
        logic        member;
        logic [1:0]  status;
    } range_result_t;

    typedef struct {
        logic [1:0]  index;
        logic [63:0] data;
    } cfg_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [71:0] m_tdata;

    // predictor copy of the range registers
    longint range_start = 0;
    longint range_stop = 0;
    longint range_step = 1;

    logic [63:0]   query_queue[$];
    cfg_write_t    cfg_queue[$];
    range_result_t expected_results[$];
    int  fail_count = 0;
    bit  idle_enable = 1'b1;
    int  send_gap = 0;
    int  recv_gap = 0;
    longint cycle_count = 0;

    stepped_range_size_and_membership #(.DATA_WIDTH(64)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    // a - b fits in 64 signed bits
    function automatic bit diff_fits(longint a, longint b);
        longint r;
        r = a - b;
        return (a[63] == b[63]) || (r[63] == a[63]);
    endfunction

    function automatic logic [63:0] magnitude(longint x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic range_result_t predict_range(longint q);
        range_result_t r;
        longint span, d;
        logic [63:0] ms, mt, c;
        bit in_span;
        r.count = '0;
        r.member = 1'b0;
        r.status = ST_OK;
        if (range_step == 0)
            r.status = ST_ZERO_STEP;
        else if (!diff_fits(range_stop, range_start))
            r.status = ST_OVERFLOW;
        else begin
            span = range_stop - range_start;
            if (span[63] == range_step[63]) begin
                ms = magnitude(span);
                mt = magnitude(range_step);
                c = ms / mt + ((ms % mt) != 0 ? 64'd1 : 64'd0);
                r.count = c[63] ? {63{1'b1}} : c[62:0];
                if (diff_fits(q, range_start)) begin
                    d = q - range_start;
                    if (!range_step[63])
                        in_span = !d[63] && d < span;
                    else
                        in_span = d <= 0 && span < d;
                    r.member = in_span && (magnitude(d) % mt) == 0;
                end
            end
        end
        return r;
    endfunction

    // random 64-bit value biased toward edges and small numbers
    function automatic longint pick_value();
        case ($urandom_range(0, 7))
            0: return SMIN + $urandom_range(0, 3);
            1: return SMAX - $urandom_range(0, 3);
            2: return longint'($urandom_range(0, 40)) - 20;
            3: return {$urandom, $urandom};
            default: return longint'($signed($urandom_range(0, 2000))) - 1000;
        endcase
    endfunction

    // config driver
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            void'(cfg_queue.pop_front());
        if (cfg_queue.size() > 0 && !(cfg_valid && cfg_ready && cfg_queue.size() == 0))
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_queue[0].index;
            cfg_data  <= cfg_queue[0].data;
        end
        else
            cfg_valid <= 1'b0;
    end

    // query driver: beat leaves the queue on acceptance, prediction made then
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            expected_results.push_back(predict_range(longint'(query_queue.pop_front())));
            if (idle_enable && $urandom_range(0, 9) == 0)
                send_gap = $urandom_range(1, 12);
        end
        if (send_gap > 0)
        begin
            send_gap = send_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if (query_queue.size() > 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= query_queue[0];
        end
        else
            s_tvalid <= 1'b0;
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        range_result_t e;
        cycle_count <= cycle_count + 1;
        if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                fail_count = fail_count + 1;
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_tdata[62:0] !== e.count || m_tdata[63] !== e.member
                    || m_tdata[65:64] !== e.status || m_tdata[71:66] !== '0)
                begin
                    $display("%0t: mismatch expected count %h member %b status %0d, got %h",
                             $time, e.count, e.member, e.status, m_tdata);
                    fail_count = fail_count + 1;
                end
            end
        end
        if (recv_gap > 0)
        begin
            recv_gap = recv_gap - 1;
            m_tready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 11) == 0)
        begin
            recv_gap = $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // waits for the pipeline to drain, then writes the start, stop and step registers
    task automatic set_range(longint start_v, longint stop_v, longint step_v);
        while (query_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_queue.push_back('{CFG_START, start_v});
        cfg_queue.push_back('{CFG_STOP, stop_v});
        cfg_queue.push_back('{CFG_STEP, step_v});
        while (cfg_queue.size() > 0 || cfg_valid)
            @(posedge clk);
        range_start = start_v;
        range_stop = stop_v;
        range_step = step_v;
    endtask

    // queries around the range: elements, neighbors, bounds, extremes
    task automatic queue_queries(int n);
        longint q;
        repeat (n)
        begin
            case ($urandom_range(0, 4))
                0: q = range_start + range_step * longint'($urandom_range(0, 30));
                1: q = range_start + range_step * longint'($urandom_range(0, 30))
                       + longint'($urandom_range(0, 2)) - 1;
                2: q = range_stop + longint'($urandom_range(0, 4)) - 2;
                default: q = pick_value();
            endcase
            query_queue.push_back(q);
        end
    endtask

    initial
    begin
        longint st, sp, sg;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset range is empty: start 0, stop 0, step 1
        query_queue.push_back(64'd0);
        query_queue.push_back(SMIN);
        query_queue.push_back(SMAX);
        queue_queries(3);

        // directed settings: extremes and each special case
        set_range(0, 10, 3);
        queue_queries(6);
        query_queue.push_back(SMAX);
        set_range(5, 5, 0);                  // zero step
        queue_queries(2);
        set_range(SMIN, SMAX, 1);            // stop - start overflows
        queue_queries(2);
        set_range(10, 0, 2);                 // span and step disagree in sign
        queue_queries(2);
        set_range(SMAX, -1, -1);             // span is most negative
        queue_queries(2);
        set_range(0, SMIN, -1);              // count saturates
        query_queue.push_back(SMAX);         // query far away
        query_queue.push_back(SMIN + 1);
        query_queue.push_back(0);
        set_range(SMAX, SMIN + 1, SMIN);     // most negative step
        queue_queries(3);

        // random phases; the last one runs without idling
        for (int phase = 0; phase < 60; phase++)
        begin
            st = pick_value();
            sg = ($urandom_range(0, 19) == 0) ? 0 : pick_value();
            if (sg != 0 && $urandom_range(0, 3) != 0)
                sg = longint'($urandom_range(1, 9)) * (($urandom_range(0, 1) != 0) ? 1 : -1);
            sp = ($urandom_range(0, 2) == 0) ? pick_value()
                 : st + sg * longint'($urandom_range(0, 40)) - longint'($urandom_range(0, 2));
            set_range(st, sp, sg);
            if (phase == 59)
                idle_enable = 1'b0;
            queue_queries(24);
        end

        while (query_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
